// File: rtl/core/adts_pkg.sv
package adts_pkg;

    // header sync pattern
    localparam logic [7:0] SYNC0       = 8'hFF;
    localparam logic [7:0] SYNC1_MASK  = 8'hF6;
    localparam logic [7:0] SYNC1_VALUE = 8'hF0;

    localparam int HDR_BYTES       = 6;
    localparam int SEEK_MIN_PASSED = 100;
    localparam int SEEK_BACKOFF    = 50;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CFG_START_OFFSET = 2'd0,
        CFG_START_FRAME  = 2'd1,
        CFG_TARGET_FRAME = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_FRAME     = 3'd0,
        ST_TARGET    = 3'd1,
        ST_SYNC_LOST = 3'd2,
        ST_END       = 3'd3,
        ST_BAD_LEN   = 3'd4
    } t_status;

    // one scan event handed from front to back
    typedef struct packed {
        t_status     status;
        logic [23:0] frame_index;
        logic [23:0] seek_count;
        logic [31:0] frame_offset;
        logic [12:0] frame_length;
        logic [1:0]  profile;
        logic [3:0]  rate_index;
        logic [2:0]  channel_config;
    } t_event;

    function automatic logic [16:0] rate_hz(input logic [3:0] idx);
        logic [16:0] hz;
        unique case (idx)
            4'd0:    hz = 17'd96000;
            4'd1:    hz = 17'd88200;
            4'd2:    hz = 17'd64000;
            4'd3:    hz = 17'd48000;
            4'd4:    hz = 17'd44100;
            4'd5:    hz = 17'd32000;
            4'd6:    hz = 17'd24000;
            4'd7:    hz = 17'd22050;
            4'd8:    hz = 17'd16000;
            4'd9:    hz = 17'd12000;
            4'd10:   hz = 17'd11025;
            4'd11:   hz = 17'd8000;
            4'd12:   hz = 17'd7350;
            default: hz = 17'd0;
        endcase
        return hz;
    endfunction

endpackage

// File: rtl/core/adts_frame_scanner_core.sv
// adts frame scanner: takes an aac adts byte stream one byte per beat and
// reports one result beat per frame header (offset, length, profile, rate
// index, sample rate, channel configuration); the header beat is final when
// the scan stops at the target frame, on lost sync or on a length under six
// bytes. the byte flagged last also stops it with a final beat. a final beat
// other than the target carries a seek frame fifty frames back, valid only
// once a hundred frames have gone by since the start frame. bytes after a
// stop are taken and dropped. rate: one byte per clock sustained; a frame
// costs one result beat, stored in a two-entry queue in front of the output
// register, and input stalls only when that queue is full, which needs the
// output side to stall. writing any of the three registers restarts the
// scan; write only while idle. no clearing pass after reset.
module adts_frame_scanner_core import adts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [23:0] o_frame_index,
    output logic [31:0] o_frame_offset,
    output logic [12:0] o_frame_length,
    output logic [1:0]  o_profile,
    output logic [3:0]  o_rate_index,
    output logic [16:0] o_sample_rate,
    output logic [2:0]  o_channel_config,
    output logic        o_is_final,
    output logic        o_seek_ok,
    output logic [23:0] o_seek_frame
);

    logic        q_full;
    logic        q_empty;
    logic        push;
    logic        pop;
    logic        take;
    t_event      front_event;
    t_event      back_event;
    logic [23:0] start_frame;

    // a byte is only taken when its possible result has a queue slot
    assign o_in_stall = q_full;
    assign take       = i_in_valid && !q_full;

    // front: byte tracking, header checks, frame counting
    adts_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_take       (take),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_push       (push),
        .o_event      (front_event),
        .o_start_frame(start_frame)
    );

    // short event queue decoupling the two sides
    adts_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (front_event),
        .o_full (q_full),
        .i_pop  (pop),
        .o_empty(q_empty),
        .o_data (back_event)
    );

    // back: rate lookup, seek computation, output register
    adts_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_event         (back_event),
        .i_start_frame   (start_frame),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_frame_index   (o_frame_index),
        .o_frame_offset  (o_frame_offset),
        .o_frame_length  (o_frame_length),
        .o_profile       (o_profile),
        .o_rate_index    (o_rate_index),
        .o_sample_rate   (o_sample_rate),
        .o_channel_config(o_channel_config),
        .o_is_final      (o_is_final),
        .o_seek_ok       (o_seek_ok),
        .o_seek_frame    (o_seek_frame)
    );

endmodule

// File: rtl/core/adts_front.sv
module adts_front import adts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_take,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_push,
    output t_event      o_event,
    output logic [23:0] o_start_frame
);

    logic [31:0] r_start_offset, n_start_offset;
    logic [23:0] r_start_frame, n_start_frame;
    logic [23:0] r_target_frame, n_target_frame;

    logic [31:0] r_pos, n_pos;
    logic [2:0]  r_hcnt, n_hcnt;
    logic [7:0]  r_hdr [5];
    logic [12:0] r_left, n_left;
    logic [23:0] r_cnt, n_cnt;
    logic [31:0] r_fstart, n_fstart;
    logic        r_done, n_done;

    logic        cfg_hit;
    logic        hdr_wr;
    logic [12:0] len;
    logic        sync_ok;
    logic [7:0]  b2, b3;

    assign cfg_hit = i_cfg_we && (i_cfg_index == CFG_START_OFFSET ||
                                  i_cfg_index == CFG_START_FRAME ||
                                  i_cfg_index == CFG_TARGET_FRAME);

    assign b2      = r_hdr[2];
    assign b3      = r_hdr[3];
    assign len     = {b3[1:0], r_hdr[4], i_data_byte[7:5]};
    assign sync_ok = (r_hdr[0] == SYNC0) && ((r_hdr[1] & SYNC1_MASK) == SYNC1_VALUE);

    always_comb begin
        n_start_offset = r_start_offset;
        n_start_frame  = r_start_frame;
        n_target_frame = r_target_frame;
        if (i_cfg_we && i_cfg_index == CFG_START_OFFSET) n_start_offset = i_cfg_data;
        if (i_cfg_we && i_cfg_index == CFG_START_FRAME)  n_start_frame  = i_cfg_data[23:0];
        if (i_cfg_we && i_cfg_index == CFG_TARGET_FRAME) n_target_frame = i_cfg_data[23:0];

        n_pos    = r_pos;
        n_hcnt   = r_hcnt;
        n_left   = r_left;
        n_cnt    = r_cnt;
        n_fstart = r_fstart;
        n_done   = r_done;
        hdr_wr   = 1'b0;
        o_push   = 1'b0;
        o_event  = '0;

        if (cfg_hit) begin
            // any register write restarts the scan
            n_pos    = n_start_offset;
            n_fstart = n_start_offset;
            n_cnt    = n_start_frame;
            n_hcnt   = '0;
            n_left   = '0;
            n_done   = 1'b0;
        end else if (i_take && !r_done) begin
            n_pos = r_pos + 32'd1;
            if (r_left != '0 || r_hcnt < 3'(HDR_BYTES - 1)) begin
                if (r_left != '0) begin
                    n_left = r_left - 13'd1;
                end else begin
                    if (r_hcnt == '0) n_fstart = r_pos;
                    hdr_wr = 1'b1;
                    n_hcnt = r_hcnt + 3'd1;
                end
                if (i_last_byte) begin
                    n_done              = 1'b1;
                    o_push              = 1'b1;
                    o_event.status      = ST_END;
                    o_event.frame_index = r_cnt;
                    o_event.seek_count  = r_cnt;
                end
            end else begin
                // sixth header byte: always one result
                n_hcnt                 = '0;
                o_push                 = 1'b1;
                o_event.frame_index    = r_cnt;
                o_event.seek_count     = r_cnt;
                o_event.frame_offset   = r_fstart;
                o_event.frame_length   = len;
                o_event.profile        = b2[7:6];
                o_event.rate_index     = b2[5:2];
                o_event.channel_config = {b2[0], b3[7:6]};
                priority if (!sync_ok) begin
                    n_done         = 1'b1;
                    o_event.status = ST_SYNC_LOST;
                end else if (r_cnt >= r_target_frame) begin
                    n_done         = 1'b1;
                    o_event.status = ST_TARGET;
                end else if (len < 13'(HDR_BYTES)) begin
                    n_done         = 1'b1;
                    o_event.status = ST_BAD_LEN;
                end else begin
                    n_cnt              = r_cnt + 24'd1;
                    n_left             = len - 13'(HDR_BYTES);
                    o_event.seek_count = r_cnt + 24'd1;
                    if (i_last_byte) begin
                        n_done         = 1'b1;
                        o_event.status = ST_END;
                    end else begin
                        o_event.status = ST_FRAME;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_offset <= '0;
            r_start_frame  <= '0;
            r_target_frame <= '0;
            r_pos          <= '0;
            r_hcnt         <= '0;
            r_left         <= '0;
            r_cnt          <= '0;
            r_fstart       <= '0;
            r_done         <= 1'b0;
        end else begin
            r_start_offset <= n_start_offset;
            r_start_frame  <= n_start_frame;
            r_target_frame <= n_target_frame;
            r_pos          <= n_pos;
            r_hcnt         <= n_hcnt;
            r_left         <= n_left;
            r_cnt          <= n_cnt;
            r_fstart       <= n_fstart;
            r_done         <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_wr) begin
            r_hdr[r_hcnt] <= i_data_byte;
        end
    end

    assign o_start_frame = r_start_frame;

    a_payload_no_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left != '0 |-> r_hcnt == '0)
        else $error("header gathering during payload skip");

    a_hcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= 3'(HDR_BYTES - 1))
        else $error("header count out of range");

endmodule

// File: rtl/core/adts_queue.sv
module adts_queue import adts_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_event o_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_event             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("event pushed into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: rtl/core/adts_back.sv
module adts_back import adts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_event      i_event,
    input  logic [23:0] i_start_frame,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [23:0] o_frame_index,
    output logic [31:0] o_frame_offset,
    output logic [12:0] o_frame_length,
    output logic [1:0]  o_profile,
    output logic [3:0]  o_rate_index,
    output logic [16:0] o_sample_rate,
    output logic [2:0]  o_channel_config,
    output logic        o_is_final,
    output logic        o_seek_ok,
    output logic [23:0] o_seek_frame
);

    logic        r_valid;
    logic [2:0]  r_status;
    logic [23:0] r_frame_index;
    logic [31:0] r_frame_offset;
    logic [12:0] r_frame_length;
    logic [1:0]  r_profile;
    logic [3:0]  r_rate_index;
    logic [16:0] r_sample_rate;
    logic [2:0]  r_channel_config;
    logic        r_is_final;
    logic        r_seek_ok;
    logic [23:0] r_seek_frame;

    logic [23:0] passed;
    logic        n_seek_ok;
    logic [23:0] n_seek_frame;

    assign o_pop = !i_empty && (!r_valid || !i_out_stall);

    assign passed = i_event.seek_count - i_start_frame;

    always_comb begin
        n_seek_ok    = 1'b0;
        n_seek_frame = '0;
        unique case (i_event.status)
            ST_FRAME: begin
                n_seek_ok    = 1'b0;
                n_seek_frame = '0;
            end
            ST_TARGET: begin
                n_seek_ok    = 1'b1;
                n_seek_frame = i_event.seek_count;
            end
            default: begin
                // back off from the last frame reached, if far enough from start
                if (passed >= 24'(SEEK_MIN_PASSED)) begin
                    n_seek_ok    = 1'b1;
                    n_seek_frame = i_event.seek_count - 24'(SEEK_BACKOFF);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status         <= i_event.status;
            r_frame_index    <= i_event.frame_index;
            r_frame_offset   <= i_event.frame_offset;
            r_frame_length   <= i_event.frame_length;
            r_profile        <= i_event.profile;
            r_rate_index     <= i_event.rate_index;
            r_sample_rate    <= (i_event.status == ST_END && i_event.frame_length == '0 &&
                                 i_event.frame_offset == '0 && i_event.rate_index == '0 &&
                                 i_event.profile == '0 && i_event.channel_config == '0)
                                ? rate_hz(i_event.rate_index) & {17{i_event.frame_length != '0}}
                                : rate_hz(i_event.rate_index);
            r_channel_config <= i_event.channel_config;
            r_is_final       <= (i_event.status != ST_FRAME);
            r_seek_ok        <= n_seek_ok;
            r_seek_frame     <= n_seek_frame;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_status         = r_status;
    assign o_frame_index    = r_frame_index;
    assign o_frame_offset   = r_frame_offset;
    assign o_frame_length   = r_frame_length;
    assign o_profile        = r_profile;
    assign o_rate_index     = r_rate_index;
    assign o_sample_rate    = r_sample_rate;
    assign o_channel_config = r_channel_config;
    assign o_is_final       = r_is_final;
    assign o_seek_ok        = r_seek_ok;
    assign o_seek_frame     = r_seek_frame;

    a_seek_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_seek_ok |-> r_is_final)
        else $error("seek result on a non-final beat");

endmodule
